>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the glyph rectangle generator.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define G2FR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Condition must never be seen outside reset.
`define G2FR_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);

`endif

>>> hdl/g2fr_pkg.sv
// ---------------------------------------------------------------------------
// g2fr_pkg
// Types, constants and the 5x7 glyph ROM of the glyph rectangle generator.
// ---------------------------------------------------------------------------
package g2fr_pkg;

  // Coordinates reach 255 + 31*6*15 + 5*15, so 12 bits never wrap.
  localparam int COORD_W     = 12;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 8;
  // Background cell plus one candidate square per glyph bit.
  localparam int MASK_W      = 1 + GLYPH_COLS * GLYPH_ROWS;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 48;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_BANG    = 8'h21;

  localparam logic [5:0] DIGIT_BASE = 6'd26;
  localparam logic [5:0] BANG_INDEX = 6'd36;
  localparam logic [5:0] NO_GLYPH   = 6'd63;

  typedef logic [COORD_W-1:0] coord_t;
  // Column 0 sits at index 0; bit r of a column is glyph row r.
  typedef logic [0:GLYPH_COLS-1][7:0] glyph_t;

  // Placement of one character cell, ready for emission.
  typedef struct packed {
    coord_t                   cell_x;
    coord_t                   cell_y;
    coord_t [GLYPH_COLS-1:0]  col_x;
    coord_t [GLYPH_ROWS-1:0]  row_y;
    logic [3:0]               scale;
    logic [15:0]              fg;
    logic [15:0]              bg;
  } job_t;

  function automatic logic [5:0] glyph_index(input logic [7:0] ch);
    logic [5:0] idx;
    idx = NO_GLYPH;
    if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
      idx = 6'(ch - CHAR_UPPER_A);
    end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
      idx = DIGIT_BASE + 6'(ch - CHAR_DIGIT_0);
    end else if (ch == CHAR_BANG) begin
      idx = BANG_INDEX;
    end
    return idx;
  endfunction

  function automatic glyph_t glyph_rom(input logic [5:0] idx);
    glyph_t g;
    case (idx)
      6'd0:  g = {8'd126, 8'd17,  8'd17,  8'd17,  8'd126};
      6'd1:  g = {8'd127, 8'd73,  8'd73,  8'd73,  8'd54};
      6'd2:  g = {8'd62,  8'd65,  8'd65,  8'd65,  8'd34};
      6'd3:  g = {8'd127, 8'd65,  8'd65,  8'd34,  8'd28};
      6'd4:  g = {8'd127, 8'd73,  8'd73,  8'd73,  8'd65};
      6'd5:  g = {8'd127, 8'd9,   8'd9,   8'd9,   8'd1};
      6'd6:  g = {8'd62,  8'd65,  8'd73,  8'd73,  8'd122};
      6'd7:  g = {8'd127, 8'd8,   8'd8,   8'd8,   8'd127};
      6'd8:  g = {8'd0,   8'd65,  8'd127, 8'd65,  8'd0};
      6'd9:  g = {8'd32,  8'd64,  8'd65,  8'd63,  8'd1};
      6'd10: g = {8'd127, 8'd8,   8'd20,  8'd34,  8'd65};
      6'd11: g = {8'd127, 8'd64,  8'd64,  8'd64,  8'd64};
      6'd12: g = {8'd127, 8'd2,   8'd12,  8'd2,   8'd127};
      6'd13: g = {8'd127, 8'd4,   8'd8,   8'd16,  8'd127};
      6'd14: g = {8'd62,  8'd65,  8'd65,  8'd65,  8'd62};
      6'd15: g = {8'd127, 8'd9,   8'd9,   8'd9,   8'd6};
      6'd16: g = {8'd62,  8'd65,  8'd81,  8'd33,  8'd94};
      6'd17: g = {8'd127, 8'd9,   8'd25,  8'd41,  8'd70};
      6'd18: g = {8'd70,  8'd73,  8'd73,  8'd73,  8'd49};
      6'd19: g = {8'd1,   8'd1,   8'd127, 8'd1,   8'd1};
      6'd20: g = {8'd63,  8'd64,  8'd64,  8'd64,  8'd63};
      6'd21: g = {8'd31,  8'd32,  8'd64,  8'd32,  8'd31};
      6'd22: g = {8'd63,  8'd64,  8'd56,  8'd64,  8'd63};
      6'd23: g = {8'd99,  8'd20,  8'd8,   8'd20,  8'd99};
      6'd24: g = {8'd7,   8'd8,   8'd112, 8'd8,   8'd7};
      6'd25: g = {8'd97,  8'd81,  8'd73,  8'd69,  8'd67};
      6'd26: g = {8'd62,  8'd81,  8'd73,  8'd69,  8'd62};
      6'd27: g = {8'd0,   8'd66,  8'd127, 8'd64,  8'd0};
      6'd28: g = {8'd66,  8'd97,  8'd81,  8'd73,  8'd70};
      6'd29: g = {8'd33,  8'd65,  8'd69,  8'd75,  8'd49};
      6'd30: g = {8'd24,  8'd20,  8'd18,  8'd127, 8'd16};
      6'd31: g = {8'd39,  8'd69,  8'd69,  8'd69,  8'd57};
      6'd32: g = {8'd60,  8'd74,  8'd73,  8'd73,  8'd48};
      6'd33: g = {8'd1,   8'd113, 8'd9,   8'd5,   8'd3};
      6'd34: g = {8'd54,  8'd73,  8'd73,  8'd73,  8'd54};
      6'd35: g = {8'd6,   8'd73,  8'd73,  8'd41,  8'd30};
      6'd36: g = {8'd0,   8'd0,   8'd95,  8'd0,   8'd0};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

>>> hdl/glyph_to_fill_rect_generator.sv
// ---------------------------------------------------------------------------
// glyph_to_fill_rect_generator
// Turns one character into clipped fill-rectangle words for the panel.
// ---------------------------------------------------------------------------
//
//  channel  direction  word                          end marker
//  in_*     input      one character with placement  none
//  out_*    output     one clipped fill rectangle    tlast on final rect
//
//  One rectangle leaves per cycle unless out_tready stalls; a character
//  sends one rectangle per visible mask bit (1 to 41), drained lowest bit
//  first from the job mask. A character with nothing visible (scale zero,
//  or all off-panel) emits nothing. A character passes the input, job and
//  output registers before its first rectangle leaves.
//  Reset (rst_n low, synchronous) empties the input, job and output stages.
//  Stalls on out_tready hold the output word; the next character still
//  lands in the input register while the current one drains.
//
`include "assert_macros.svh"

module glyph_to_fill_rect_generator #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 160
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] char_code, [15:8] origin_x, [23:16] origin_y,
  // [28:24] slot_from_right, [44:29] fg_color, [60:45] bg_color,
  // [64:61] scale, [71:65] zero
  input  logic [g2fr_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [6:0] rect_x, [14:7] rect_y, [22:15] rect_w, [30:23] rect_h,
  // [46:31] rect_color, [47] zero
  output logic [g2fr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast
);

  // Input stage: raw character word.
  logic        a_valid_r;
  logic        a_valid_nxt;
  logic [7:0]  a_char_r;
  logic [7:0]  a_ox_r;
  logic [7:0]  a_oy_r;
  logic [4:0]  a_slot_r;
  logic [15:0] a_fg_r;
  logic [15:0] a_bg_r;
  logic [3:0]  a_scale_r;
  logic        in_fire;

  // Job stage: placed cell and the rectangles still to send.
  g2fr_pkg::job_t              job_nxt;
  g2fr_pkg::job_t              job_r;
  logic [g2fr_pkg::MASK_W-1:0] mask_new;
  logic [g2fr_pkg::MASK_W-1:0] job_mask_r;
  logic [g2fr_pkg::MASK_W-1:0] job_mask_nxt;
  logic [g2fr_pkg::MASK_W-1:0] rest;
  logic [g2fr_pkg::MASK_W-1:0] pick_oh;
  logic                        job_last;
  logic                        job_free;
  logic                        a_to_b;

  // Emission.
  logic [5:0]       pick_idx;
  logic [5:0]       glyph_bit;
  logic [2:0]       pick_col;
  logic [2:0]       pick_row;
  logic             is_bg;
  g2fr_pkg::coord_t pick_x;
  g2fr_pkg::coord_t pick_y;
  logic [6:0]       w_full;
  logic [6:0]       h_full;
  g2fr_pkg::coord_t room_x;
  g2fr_pkg::coord_t room_y;
  g2fr_pkg::coord_t clip_w;
  g2fr_pkg::coord_t clip_h;
  logic             out_load;

  // Output register.
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        out_last_r;
  logic [6:0]  out_x_r;
  logic [7:0]  out_y_r;
  logic [7:0]  out_w_r;
  logic [7:0]  out_h_r;
  logic [15:0] out_color_r;

  // ---- handshake -----------------------------------------------------------
  // The input register frees up as soon as its character moves to the job
  // stage, which happens when the job stage empties in this same cycle.
  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !a_valid_r || a_to_b;

  assign out_load  = (job_mask_r != '0) && (!out_valid_r || out_tready);
  // Lowest pending rectangle goes next; rest is what stays behind.
  assign rest      = job_mask_r & (job_mask_r - g2fr_pkg::MASK_W'(1));
  assign pick_oh   = job_mask_r & ~rest;
  assign job_last  = (rest == '0);
  assign job_free  = (job_mask_r == '0) || (out_load && job_last);
  assign a_to_b    = a_valid_r && job_free;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_fire) begin
      a_valid_nxt = 1'b1;
    end else if (a_to_b) begin
      a_valid_nxt = 1'b0;
    end
    job_mask_nxt = job_mask_r;
    if (a_to_b) begin
      job_mask_nxt = mask_new;
    end else if (out_load) begin
      job_mask_nxt = rest;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---- placement -----------------------------------------------------------
  g2fr_layout #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_layout (
    .char_code       (a_char_r),
    .origin_x        (a_ox_r),
    .origin_y        (a_oy_r),
    .slot_from_right (a_slot_r),
    .fg_color        (a_fg_r),
    .bg_color        (a_bg_r),
    .scale           (a_scale_r),
    .job             (job_nxt),
    .mask            (mask_new)
  );

  // ---- emission ------------------------------------------------------------
  // Decode the picked bit: bit 0 is the background cell, bit 1+8c+r is the
  // glyph square of column c, row r.
  always_comb begin
    pick_idx = '0;
    for (int k = 0; k < g2fr_pkg::MASK_W; k++) begin
      if (pick_oh[k]) begin
        pick_idx = 6'(k);
      end
    end
  end

  assign is_bg     = pick_oh[0];
  assign glyph_bit = pick_idx - 6'd1;
  assign pick_col  = glyph_bit[5:3];
  assign pick_row  = glyph_bit[2:0];
  assign pick_x    = is_bg ? job_r.cell_x : job_r.col_x[pick_col];
  assign pick_y    = is_bg ? job_r.cell_y : job_r.row_y[pick_row];
  // Background is 6 by 8 squares; x6 by shifted adds, x8 by a shift.
  assign w_full    = is_bg ? ({1'b0, job_r.scale, 2'b00} + {2'b00, job_r.scale, 1'b0})
                           : {3'b000, job_r.scale};
  assign h_full    = is_bg ? {job_r.scale, 3'b000} : {3'b000, job_r.scale};

  // Trim to the panel edge; the mask already guarantees x and y are on it.
  assign room_x = g2fr_pkg::coord_t'(PANEL_WIDTH) - pick_x;
  assign room_y = g2fr_pkg::coord_t'(PANEL_HEIGHT) - pick_y;
  assign clip_w = (g2fr_pkg::coord_t'(w_full) > room_x) ? room_x
                                                        : g2fr_pkg::coord_t'(w_full);
  assign clip_h = (g2fr_pkg::coord_t'(h_full) > room_y) ? room_y
                                                        : g2fr_pkg::coord_t'(h_full);

  // ---- registers -----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      job_mask_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      job_mask_r  <= job_mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_char_r  <= in_tdata[7:0];
      a_ox_r    <= in_tdata[15:8];
      a_oy_r    <= in_tdata[23:16];
      a_slot_r  <= in_tdata[28:24];
      a_fg_r    <= in_tdata[44:29];
      a_bg_r    <= in_tdata[60:45];
      a_scale_r <= in_tdata[64:61];
    end
    if (a_to_b) begin
      job_r <= job_nxt;
    end
    if (out_load) begin
      out_x_r     <= pick_x[6:0];
      out_y_r     <= pick_y[7:0];
      out_w_r     <= clip_w[7:0];
      out_h_r     <= clip_h[7:0];
      out_color_r <= is_bg ? job_r.bg : job_r.fg;
      out_last_r  <= job_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_color_r, out_h_r, out_w_r, out_y_r, out_x_r};

  // ---- checks --------------------------------------------------------------
  `G2FR_ASSERT(a_pick_onehot, clk, rst_n, (job_mask_r != '0) |-> $onehot(pick_oh), "pick not one-hot")
  `G2FR_ASSERT(a_job_keeps_work, clk, rst_n, (out_load && !job_last) |=> (job_mask_r != '0), "job lost rectangles")
  `G2FR_ASSERT(a_held_item, clk, rst_n, (a_valid_r && !a_to_b) |=> a_valid_r, "input word dropped")
  `G2FR_ASSERT_NEVER(a_rect_nonempty, clk, rst_n, out_valid_r && (out_w_r == '0 || out_h_r == '0), "empty rectangle")

endmodule

>>> hdl/g2fr_layout.sv
// ---------------------------------------------------------------------------
// g2fr_layout
// Places one character cell: column and row positions and the visible mask.
// ---------------------------------------------------------------------------
module g2fr_layout #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 160
) (
  input  logic [7:0]                  char_code,
  input  logic [7:0]                  origin_x,
  input  logic [7:0]                  origin_y,
  input  logic [4:0]                  slot_from_right,
  input  logic [15:0]                 fg_color,
  input  logic [15:0]                 bg_color,
  input  logic [3:0]                  scale,
  output g2fr_pkg::job_t              job,
  output logic [g2fr_pkg::MASK_W-1:0] mask
);

  logic [8:0]                          slot_sc;
  logic [11:0]                         span;
  g2fr_pkg::coord_t                    cell_x;
  g2fr_pkg::glyph_t                    glyph;
  logic [g2fr_pkg::GLYPH_COLS-1:0]     col_vis;
  logic [g2fr_pkg::GLYPH_ROWS-1:0]     row_vis;

  // Cell x = origin + slot * 6 * scale; the x6 is two shifted adds.
  assign slot_sc = {4'b0000, slot_from_right} * {5'b00000, scale};
  assign span    = {1'b0, slot_sc, 2'b00} + {2'b00, slot_sc, 1'b0};
  assign cell_x  = g2fr_pkg::coord_t'(origin_x) + g2fr_pkg::coord_t'(span);
  assign glyph   = g2fr_pkg::glyph_rom(g2fr_pkg::glyph_index(char_code));

  always_comb begin
    job.cell_x = cell_x;
    job.cell_y = g2fr_pkg::coord_t'(origin_y);
    job.scale  = scale;
    job.fg     = fg_color;
    job.bg     = bg_color;
    // Rotated glyph: column c lands at offset 5-c, row r at offset 7-r.
    for (int c = 0; c < g2fr_pkg::GLYPH_COLS; c++) begin
      job.col_x[c] = cell_x + g2fr_pkg::coord_t'(scale)
                     * g2fr_pkg::coord_t'(g2fr_pkg::GLYPH_COLS - c);
      col_vis[c]   = job.col_x[c] < g2fr_pkg::coord_t'(PANEL_WIDTH);
    end
    for (int r = 0; r < g2fr_pkg::GLYPH_ROWS; r++) begin
      job.row_y[r] = g2fr_pkg::coord_t'(origin_y) + g2fr_pkg::coord_t'(scale)
                     * g2fr_pkg::coord_t'(g2fr_pkg::GLYPH_ROWS - 1 - r);
      row_vis[r]   = job.row_y[r] < g2fr_pkg::coord_t'(PANEL_HEIGHT);
    end
    mask[0] = (scale != 4'd0) && (cell_x < g2fr_pkg::coord_t'(PANEL_WIDTH))
              && (g2fr_pkg::coord_t'(origin_y) < g2fr_pkg::coord_t'(PANEL_HEIGHT));
    for (int c = 0; c < g2fr_pkg::GLYPH_COLS; c++) begin
      for (int r = 0; r < g2fr_pkg::GLYPH_ROWS; r++) begin
        mask[1 + c * g2fr_pkg::GLYPH_ROWS + r] = (scale != 4'd0) && glyph[c][r]
                                                 && col_vis[c] && row_vis[r];
      end
    end
  end

endmodule

>>> tb/fill_rect_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fill_rect_checker
// Watches both channels of the glyph rectangle generator. Rasterizes every
// accepted character into the clipped fill rectangles it should produce and
// compares each rectangle leaving the block, field by field, in order.
// ---------------------------------------------------------------------------
module fill_rect_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [g2fr_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [g2fr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tlast,
  output int                               mismatch_count,
  output int                               rects_pending
);

  localparam int PANEL_W = 128;
  localparam int PANEL_H = 160;
  localparam int MAX_RECTS = 41;

  // Input word, highest field first.
  typedef struct packed {
    logic [6:0]  pad;
    logic [3:0]  scale;
    logic [15:0] bg_color;
    logic [15:0] fg_color;
    logic [4:0]  slot;
    logic [7:0]  origin_y;
    logic [7:0]  origin_x;
    logic [7:0]  char_code;
  } char_word_t;

  // Output word, highest field first.
  typedef struct packed {
    logic        pad;
    logic [15:0] color;
    logic [7:0]  h;
    logic [7:0]  w;
    logic [7:0]  y;
    logic [6:0]  x;
  } rect_word_t;

  typedef struct packed {
    logic [6:0]  x;
    logic [7:0]  y;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [15:0] color;
    logic        last;
  } fill_rect_t;

  fill_rect_t rects_due[$];

  function automatic logic [39:0] cols(input int c0, c1, c2, c3, c4);
    return {8'(c4), 8'(c3), 8'(c2), 8'(c1), 8'(c0)};
  endfunction

  // Column c of the glyph sits in bits [8c +: 8]; bit r is glyph row r.
  function automatic logic [39:0] font_columns(input logic [7:0] code);
    int idx;
    idx = -1;
    if (code >= g2fr_pkg::CHAR_UPPER_A && code <= g2fr_pkg::CHAR_UPPER_Z) begin
      idx = int'(code - g2fr_pkg::CHAR_UPPER_A);
    end else if (code >= g2fr_pkg::CHAR_DIGIT_0 && code <= g2fr_pkg::CHAR_DIGIT_9) begin
      idx = 26 + int'(code - g2fr_pkg::CHAR_DIGIT_0);
    end else if (code == g2fr_pkg::CHAR_BANG) begin
      idx = 36;
    end
    case (idx)
      0:  return cols(126, 17, 17, 17, 126);
      1:  return cols(127, 73, 73, 73, 54);
      2:  return cols(62, 65, 65, 65, 34);
      3:  return cols(127, 65, 65, 34, 28);
      4:  return cols(127, 73, 73, 73, 65);
      5:  return cols(127, 9, 9, 9, 1);
      6:  return cols(62, 65, 73, 73, 122);
      7:  return cols(127, 8, 8, 8, 127);
      8:  return cols(0, 65, 127, 65, 0);
      9:  return cols(32, 64, 65, 63, 1);
      10: return cols(127, 8, 20, 34, 65);
      11: return cols(127, 64, 64, 64, 64);
      12: return cols(127, 2, 12, 2, 127);
      13: return cols(127, 4, 8, 16, 127);
      14: return cols(62, 65, 65, 65, 62);
      15: return cols(127, 9, 9, 9, 6);
      16: return cols(62, 65, 81, 33, 94);
      17: return cols(127, 9, 25, 41, 70);
      18: return cols(70, 73, 73, 73, 49);
      19: return cols(1, 1, 127, 1, 1);
      20: return cols(63, 64, 64, 64, 63);
      21: return cols(31, 32, 64, 32, 31);
      22: return cols(63, 64, 56, 64, 63);
      23: return cols(99, 20, 8, 20, 99);
      24: return cols(7, 8, 112, 8, 7);
      25: return cols(97, 81, 73, 69, 67);
      26: return cols(62, 81, 73, 69, 62);
      27: return cols(0, 66, 127, 64, 0);
      28: return cols(66, 97, 81, 73, 70);
      29: return cols(33, 65, 69, 75, 49);
      30: return cols(24, 20, 18, 127, 16);
      31: return cols(39, 69, 69, 69, 57);
      32: return cols(60, 74, 73, 73, 48);
      33: return cols(1, 113, 9, 5, 3);
      34: return cols(54, 73, 73, 73, 54);
      35: return cols(6, 73, 73, 41, 30);
      36: return cols(0, 0, 95, 0, 0);
      default: return '0;
    endcase
  endfunction

  // Drop a rectangle that starts off the panel, trim the rest to its edge.
  function automatic bit clip_to_panel(input int x, y, w, h, input logic [15:0] color,
                                       output fill_rect_t r);
    r = '0;
    if (x >= PANEL_W || y >= PANEL_H) return 1'b0;
    if (w > PANEL_W - x) w = PANEL_W - x;
    if (h > PANEL_H - y) h = PANEL_H - y;
    r.x = x[6:0];
    r.y = y[7:0];
    r.w = w[7:0];
    r.h = h[7:0];
    r.color = color;
    return 1'b1;
  endfunction

  // Queue up the rectangles one character should produce.
  function automatic void raster_char(input char_word_t cw);
    fill_rect_t batch [MAX_RECTS];
    fill_rect_t r;
    logic [39:0] glyph;
    int n, sc, cx, oy;
    n = 0;
    sc = int'(cw.scale);
    if (sc == 0) return;
    glyph = font_columns(cw.char_code);
    cx = int'(cw.origin_x) + int'(cw.slot) * 6 * sc;
    oy = int'(cw.origin_y);
    if (clip_to_panel(cx, oy, 6 * sc, 8 * sc, cw.bg_color, r)) begin
      batch[n] = r;
      n++;
    end
    // Rotated by half a turn: column c lands at 5-c, row r at 7-r.
    for (int c = 0; c < 5; c++) begin
      for (int b = 0; b < 8; b++) begin
        if (glyph[8 * c + b] &&
            clip_to_panel(cx + (5 - c) * sc, oy + (7 - b) * sc, sc, sc, cw.fg_color, r)) begin
          batch[n] = r;
          n++;
        end
      end
    end
    if (n > 0) batch[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) rects_due.push_back(batch[i]);
  endfunction

  always @(posedge clk) begin
    rect_word_t got;
    fill_rect_t want;
    if (!rst_n) begin
      rects_due.delete();
      mismatch_count = 0;
      rects_pending = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (rects_due.size() == 0) begin
          $error("unexpected rect x=%0d y=%0d w=%0d h=%0d", got.x, got.y, got.w, got.h);
          mismatch_count++;
        end else begin
          want = rects_due.pop_front();
          if (got.x !== want.x) begin
            $error("rect_x: expected %0d, got %0d", want.x, got.x);
            mismatch_count++;
          end
          if (got.y !== want.y) begin
            $error("rect_y: expected %0d, got %0d", want.y, got.y);
            mismatch_count++;
          end
          if (got.w !== want.w) begin
            $error("rect_w: expected %0d, got %0d", want.w, got.w);
            mismatch_count++;
          end
          if (got.h !== want.h) begin
            $error("rect_h: expected %0d, got %0d", want.h, got.h);
            mismatch_count++;
          end
          if (got.color !== want.color) begin
            $error("rect_color: expected %h, got %h", want.color, got.color);
            mismatch_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last_rect: expected %0b, got %0b", want.last, out_tlast);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) raster_char(in_tdata);
      rects_pending = rects_due.size();
    end
  end

endmodule

>>> tb/tb_glyph_to_fill_rect_generator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_glyph_to_fill_rect_generator
// Drives characters into the glyph rectangle generator with random pacing
// on both sides and lets fill_rect_checker judge every rectangle.
// ---------------------------------------------------------------------------
module tb_glyph_to_fill_rect_generator;

  // Long sink hold-off: long enough for the block to fill and stall input.
  localparam int LONG_HOLD = 400;
  // Cycles with no word moving on either channel before giving up.
  localparam int WATCHDOG_LIMIT = 4000;
  // Quiet cycles after the last rectangle.
  localparam int DRAIN_TAIL = 20;
  localparam int RANDOM_CHARS = 350;
  localparam int BURST_START = 120;
  localparam int BURST_LEN = 30;
  localparam int DRAIN_POINT = 240;
  localparam int IN_TDATA_W = g2fr_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = g2fr_pkg::OUT_TDATA_W;

  localparam logic [7:0] CHAR_UPPER_A = g2fr_pkg::CHAR_UPPER_A;
  localparam logic [7:0] CHAR_UPPER_Z = g2fr_pkg::CHAR_UPPER_Z;
  localparam logic [7:0] CHAR_DIGIT_0 = g2fr_pkg::CHAR_DIGIT_0;
  localparam logic [7:0] CHAR_DIGIT_9 = g2fr_pkg::CHAR_DIGIT_9;
  localparam logic [7:0] CHAR_BANG    = g2fr_pkg::CHAR_BANG;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_MAX   = 8'hFF;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;

  int mismatch_count;
  int rects_pending;
  int idle_cycles;
  bit sender_calm;
  bit sink_hold_request;

  always #6 clk = ~clk;

  glyph_to_fill_rect_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  fill_rect_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .rects_pending  (rects_pending)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Pack fields lowest first: char, origin x, origin y, slot, fg, bg, scale.
  function automatic logic [IN_TDATA_W-1:0] char_word(
      input logic [7:0] code, input logic [7:0] ox, input logic [7:0] oy,
      input logic [4:0] slot, input logic [15:0] fg, input logic [15:0] bg,
      input logic [3:0] scale);
    return {7'd0, scale, bg, fg, slot, oy, ox, code};
  endfunction

  // Pick a code with a glyph most of the time, any byte otherwise.
  function automatic logic [7:0] random_code();
    int pick;
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 36);
    if (pick < 26) return CHAR_UPPER_A + 8'(pick);
    if (pick < 36) return CHAR_DIGIT_0 + 8'(pick - 26);
    return CHAR_BANG;
  endfunction

  // Mostly on-panel cells at small scales so most squares survive clipping;
  // a share of the items roam over the full field ranges.
  function automatic logic [IN_TDATA_W-1:0] random_char_word();
    logic [7:0] ox, oy;
    logic [4:0] slot;
    logic [3:0] scale;
    if ($urandom_range(0, 9) < 7) begin
      ox = 8'($urandom_range(0, 127));
      oy = 8'($urandom_range(0, 159));
      slot = 5'($urandom_range(0, 3));
      scale = 4'($urandom_range(1, 3));
    end else begin
      ox = 8'($urandom_range(0, 255));
      oy = 8'($urandom_range(0, 255));
      slot = 5'($urandom_range(0, 31));
      scale = 4'($urandom_range(0, 15));
    end
    return char_word(random_code(), ox, oy, slot, 16'($urandom), 16'($urandom), scale);
  endfunction

  // Offer one word after an optional gap and hold it until it is taken.
  task automatic send_word(input logic [IN_TDATA_W-1:0] word, input int gap);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata <= IN_TDATA_W'({$urandom, $urandom, $urandom});
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= word;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_char(input logic [7:0] code, input logic [7:0] ox, input logic [7:0] oy,
                           input logic [4:0] slot, input logic [15:0] fg,
                           input logic [15:0] bg, input logic [3:0] scale);
    send_word(char_word(code, ox, oy, slot, fg, bg, scale), gap_len());
  endtask

  // Stop offering and wait until every queued rectangle has been seen.
  task automatic drain_rects();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (rects_pending != 0) @(posedge clk);
  endtask

  // Sink pacing: random stalls, calm stretches with none, and one long
  // hold-off on request while the sender keeps pushing.
  initial begin : sink_pacing
    int stall_left;
    int span_left;
    bit calm;
    bit hold_done;
    stall_left = 0;
    span_left = 0;
    calm = 1'b0;
    hold_done = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (span_left == 0) begin
        span_left = $urandom_range(50, 300);
        calm = ($urandom_range(0, 3) == 0);
      end
      span_left--;
      if (sink_hold_request && !hold_done) begin
        hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 2) == 0) stall_left = gap_len();
      end
    end
  end

  // Watchdog: give up when no word has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $error("watchdog: no word moved for %0d cycles, %0d rects outstanding",
               idle_cycles, rects_pending);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int gap;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    sender_calm = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every glyph group, blank codes, zero scale, clipping.
    send_char(CHAR_UPPER_A, 8'd0, 8'd0, 5'd0, 16'hFFFF, 16'h0000, 4'd1);
    send_char(CHAR_UPPER_Z, 8'd10, 8'd20, 5'd0, 16'h0000, 16'hFFFF, 4'd2);
    send_char(CHAR_DIGIT_0, 8'd30, 8'd40, 5'd1, 16'hF800, 16'h07E0, 4'd1);
    send_char(CHAR_DIGIT_9, 8'd50, 8'd60, 5'd2, 16'h001F, 16'hAAAA, 4'd3);
    send_char(CHAR_BANG, 8'd0, 8'd100, 5'd0, 16'h5555, 16'h1234, 4'd2);
    send_char(CHAR_UPPER_A + 8'd7, 8'd5, 8'd5, 5'd0, 16'hFFFF, 16'hFFFF, 4'd1);
    send_char(CHAR_UPPER_A + 8'd22, 8'd64, 8'd80, 5'd0, 16'h8001, 16'h7FFE, 4'd1);
    // Codes without a glyph draw only the cell.
    send_char(CHAR_SPACE, 8'd20, 8'd20, 5'd0, 16'hFFFF, 16'h0F0F, 4'd1);
    send_char(CHAR_NUL, 8'd0, 8'd0, 5'd0, 16'h0000, 16'hFFFF, 4'd15);
    send_char(CHAR_MAX, 8'd3, 8'd7, 5'd0, 16'hFFFF, 16'h0000, 4'd4);
    send_char(CHAR_LOW_A, 8'd40, 8'd40, 5'd0, 16'h1111, 16'h2222, 4'd2);
    // Zero scale draws nothing.
    send_char(CHAR_UPPER_A, 8'd0, 8'd0, 5'd0, 16'hFFFF, 16'hFFFF, 4'd0);
    send_char(CHAR_DIGIT_0 + 8'd8, 8'd255, 8'd255, 5'd31, 16'hFFFF, 16'hFFFF, 4'd0);
    // Wholly off the panel: right of it, below it, far right via the slot.
    send_char(CHAR_UPPER_A + 8'd12, 8'd128, 8'd0, 5'd0, 16'hFFFF, 16'h0000, 4'd1);
    send_char(CHAR_UPPER_A + 8'd12, 8'd0, 8'd160, 5'd0, 16'hFFFF, 16'h0000, 4'd1);
    send_char(CHAR_DIGIT_0 + 8'd8, 8'd255, 8'd255, 5'd31, 16'hFFFF, 16'h0000, 4'd15);
    // Straddling an edge: trim to the panel.
    send_char(CHAR_UPPER_A + 8'd1, 8'd120, 8'd10, 5'd0, 16'hABCD, 16'h4321, 4'd2);
    send_char(CHAR_UPPER_A + 8'd4, 8'd10, 8'd155, 5'd0, 16'hABCD, 16'h4321, 4'd4);
    send_char(CHAR_UPPER_A + 8'd16, 8'd116, 8'd150, 5'd1, 16'hFEDC, 16'h0123, 4'd1);
    send_char(CHAR_DIGIT_0 + 8'd8, 8'd0, 8'd0, 5'd0, 16'hFFFF, 16'h0000, 4'd15);
    send_char(CHAR_DIGIT_0 + 8'd8, 8'd0, 8'd0, 5'd1, 16'h0000, 16'hFFFF, 4'd15);
    send_char(CHAR_UPPER_A + 8'd23, 8'd127, 8'd159, 5'd0, 16'hFFFF, 16'hFFFF, 4'd1);
    send_char(CHAR_UPPER_A + 8'd24, 8'd0, 8'd0, 5'd16, 16'h8000, 16'h0001, 4'd1);

    for (int i = 0; i < RANDOM_CHARS; i++) begin
      if (i % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      // Hold the sink off and push back to back so the block backs up.
      if (i == BURST_START) sink_hold_request = 1'b1;
      // Let everything drain before resuming.
      if (i == DRAIN_POINT) drain_rects();
      if (sender_calm || (i >= BURST_START && i < BURST_START + BURST_LEN)) begin
        gap = 0;
      end else begin
        gap = gap_len();
      end
      send_word(random_char_word(), gap);
    end

    drain_rects();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_count == 0 && rects_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
